>>> hdl/msct_pkg.sv
`default_nettype none

package msct_pkg;

	// Fixed field widths of the item and result.
	localparam int DUR_W   = 15;
	localparam int EV_W    = 16;
	localparam int IDX_W   = 4;
	localparam int TALLY_W = 4;
	localparam int PER_W   = 4;

	localparam logic [TALLY_W-1:0] TALLY_MAX = 4'd15;

	// Item operation codes.
	typedef enum logic [1:0] {
		MODE_SET    = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_FETCH  = 2'd2,
		MODE_REMOVE = 2'd3
	} mode_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET_WALK,
		ST_RAM_WALK,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic set_step;
		logic ram_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic set_done;
		logic ram_done;
	} sts_t;

endpackage

`default_nettype wire

>>> hdl/multi_slot_countdown_timer_table.sv
// Table of one-shot countdown timers driven by a periodic hardware timer.
// Input channel: an item (mode, duration, event_value, slot_index) is taken at
// a rising edge where start is high and busy is low. Modes: set claims the
// lowest free slot, tick counts down every live slot by the elapsed period,
// fetch returns the next expired slot from the scan cursor, remove frees a slot.
// Output channel: each item gives exactly one result, shown for a single cycle
// while done is high; the receiver cannot hold it off, so it must sample then.
// Remove goes straight to the result state; set walks the slot flags upward from
// slot zero to the lowest free slot, tick walks every slot, and fetch walks from the
// cursor until it meets an expired slot or passes the last one.
// The walk over slots is one slot per cycle; tick and fetch read the slots
// through the single read port of the remaining-time RAM.
// Busy stays high from acceptance until the result cycle; one item is handled
// at a time, and a new one may be accepted at the edge that ends the result.
// Reset (arst_n low) frees all slots at once through per-slot valid flags, sets
// the period to MAX_PERIOD, the elapsed period to one second, the cursor and
// expired count to zero. No clearing pass is needed after reset.
`default_nettype none

module multi_slot_countdown_timer_table
	import msct_pkg::*;
#(
	parameter int SLOTS      = 10,
	parameter int MAX_PERIOD = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             mode,
	input  wire logic [DUR_W-1:0]       duration,
	input  wire logic signed [EV_W-1:0] event_value,
	input  wire logic [IDX_W-1:0]       slot_index,
	output logic                        done,
	output logic [IDX_W-1:0]            slot_out,
	output logic                        slot_ok,
	output logic signed [EV_W-1:0]      event_out,
	output logic                        event_found,
	output logic [TALLY_W-1:0]          pending_expired,
	output logic [PER_W-1:0]            period_seconds,
	output logic                        period_changed
);

	cmd_t cmd;
	sts_t sts;

	msct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode_t'(mode)),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	msct_dp #(.SLOTS(SLOTS), .MAX_PERIOD(MAX_PERIOD)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode_t'(mode)),
		.duration        (duration),
		.event_value     (event_value),
		.slot_index      (slot_index),
		.done            (done),
		.slot_out        (slot_out),
		.slot_ok         (slot_ok),
		.event_out       (event_out),
		.event_found     (event_found),
		.pending_expired (pending_expired),
		.period_seconds  (period_seconds),
		.period_changed  (period_changed)
	);

	// A result is only shown once the controller has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while controller busy");

	// An accepted item always occupies the controller in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A set result and a fetch result never mix.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(slot_ok && event_found))
		else $error("result claims both a slot and an event");

	// The programmed period never exceeds the cap.
	a_period_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(period_seconds) <= MAX_PERIOD))
		else $error("period above cap");

endmodule

`default_nettype wire

>>> hdl/msct_ram.sv
`default_nettype none

module msct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/msct_ctrl.sv
`default_nettype none

module msct_ctrl
	import msct_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire mode_t mode,
	input  wire sts_t  sts,
	output cmd_t       cmd,
	output logic       busy
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_SET:    state_d = ST_SET_WALK;
						MODE_TICK:   state_d = ST_RAM_WALK;
						MODE_FETCH:  state_d = ST_RAM_WALK;
						MODE_REMOVE: state_d = ST_RESULT;
						default:     state_d = ST_RESULT;
					endcase
				end
			end
			ST_SET_WALK: begin
				if (sts.set_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RAM_WALK: begin
				if (sts.ram_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Commands and busy flag.
	always_comb begin
		cmd          = '0;
		busy         = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SET_WALK: cmd.set_step = 1'b1;
			ST_RAM_WALK: cmd.ram_step = 1'b1;
			ST_RESULT:   cmd.finish   = 1'b1;
			default:     busy         = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/msct_dp.sv
`default_nettype none

module msct_dp
	import msct_pkg::*;
#(
	parameter int SLOTS      = 10,
	parameter int MAX_PERIOD = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output sts_t                          sts,
	input  wire mode_t                    mode,
	input  wire logic [DUR_W-1:0]         duration,
	input  wire logic signed [EV_W-1:0]   event_value,
	input  wire logic [IDX_W-1:0]         slot_index,
	output logic                          done,
	output logic [IDX_W-1:0]              slot_out,
	output logic                          slot_ok,
	output logic signed [EV_W-1:0]        event_out,
	output logic                          event_found,
	output logic [TALLY_W-1:0]            pending_expired,
	output logic [PER_W-1:0]              period_seconds,
	output logic                          period_changed
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// Captured item fields.
	mode_t            mode_q;
	logic [DUR_W-1:0] dur_q;
	logic [EV_W-1:0]  ev_q;
	logic [IDX_W-1:0] sidx_q;

	// Walk control and slot flags.
	logic [CW-1:0]    cnt_q;
	logic             v_s1;
	logic [IW-1:0]    idx_s1;
	logic [SLOTS-1:0] live_q;

	// Timer state.
	logic [PER_W-1:0]   elapsed_q;
	logic [PER_W-1:0]   next_q;
	logic [CW-1:0]      cursor_q;
	logic [TALLY_W-1:0] tally_q;

	// Per-item scratch.
	logic [PER_W-1:0] nxt_q;
	logic             found_q;
	logic             ok_q;
	logic [IW-1:0]    slot_q;
	logic             changed_q;
	logic [EV_W-1:0]  fev_q;

	// Memory ports.
	logic [DUR_W-1:0] rem_rd;
	logic [EV_W-1:0]  ev_rd;
	logic             rem_we;
	logic [IW-1:0]    rem_waddr;
	logic [DUR_W-1:0] rem_wdata;
	logic             rd_en;

	logic             issue_ok;
	logic [IW-1:0]    cnt_ix;
	logic             set_free;
	logic             s1_live;
	logic             tick_hit;
	logic             fetch_hit;
	logic [DUR_W-1:0] tick_r;
	logic             remove_ok;
	logic [TALLY_W-1:0] tally_fin;
	logic [PER_W-1:0]   period_fin;

	// Walk decode: set checks the flags directly, tick and fetch go through the RAM.
	always_comb begin
		issue_ok  = cnt_q < CW'(SLOTS);
		cnt_ix    = cnt_q[IW-1:0];
		set_free  = issue_ok && !live_q[cnt_ix];
		s1_live   = live_q[idx_s1];
		tick_hit  = v_s1 && s1_live && (rem_rd != '0) && (mode_q == MODE_TICK);
		fetch_hit = v_s1 && s1_live && (rem_rd == '0) && (mode_q == MODE_FETCH);
		if (rem_rd <= DUR_W'(elapsed_q)) begin
			tick_r = '0;
		end else begin
			tick_r = rem_rd - DUR_W'(elapsed_q);
		end
		sts.set_done = !issue_ok || set_free;
		sts.ram_done = fetch_hit || (!issue_ok && !v_s1);
		remove_ok    = 32'(sidx_q) < SLOTS;
		rd_en        = cmd.ram_step && issue_ok;
	end

	// Remaining-time write port is shared by set and tick.
	always_comb begin
		rem_we    = 1'b0;
		rem_waddr = idx_s1;
		rem_wdata = tick_r;
		if (cmd.set_step && set_free) begin
			rem_we    = 1'b1;
			rem_waddr = cnt_ix;
			rem_wdata = dur_q;
		end else if (cmd.ram_step && tick_hit) begin
			rem_we = 1'b1;
		end
	end

	// Values committed at the end of the item.
	always_comb begin
		tally_fin  = tally_q;
		period_fin = next_q;
		if (mode_q == MODE_FETCH && !found_q) begin
			tally_fin = '0;
		end
		if (mode_q == MODE_TICK) begin
			period_fin = nxt_q;
		end
	end

	msct_ram #(.WIDTH(DUR_W), .DEPTH(SLOTS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.re    (rd_en),
		.raddr (cnt_ix),
		.rdata (rem_rd)
	);

	msct_ram #(.WIDTH(EV_W), .DEPTH(SLOTS)) u_ev_ram (
		.clk   (clk),
		.we    (cmd.set_step && set_free),
		.waddr (cnt_ix),
		.wdata (ev_q),
		.re    (rd_en),
		.raddr (cnt_ix),
		.rdata (ev_rd)
	);

	// Item payload capture and result values.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			dur_q  <= duration;
			ev_q   <= event_value;
			sidx_q <= slot_index;
		end
		idx_s1 <= cnt_ix;
		if (cmd.set_step && set_free) begin
			slot_q <= cnt_ix;
		end
		if (cmd.ram_step && fetch_hit) begin
			fev_q <= ev_rd;
		end
		if (cmd.finish) begin
			slot_out        <= ok_q ? IDX_W'(slot_q) : '0;
			slot_ok         <= ok_q;
			event_out       <= found_q ? fev_q : '0;
			event_found     <= found_q;
			pending_expired <= tally_fin;
			period_seconds  <= period_fin;
			period_changed  <= (mode_q == MODE_TICK) || changed_q;
		end
	end

	// Control and timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			live_q    <= '0;
			elapsed_q <= PER_W'(1);
			next_q    <= PER_W'(MAX_PERIOD);
			cursor_q  <= '0;
			tally_q   <= '0;
			nxt_q     <= PER_W'(MAX_PERIOD);
			found_q   <= 1'b0;
			ok_q      <= 1'b0;
			changed_q <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= cmd.finish;
			v_s1 <= rd_en;

			// Start of an item.
			if (cmd.load) begin
				cnt_q     <= (mode == MODE_FETCH) ? cursor_q : '0;
				nxt_q     <= PER_W'(MAX_PERIOD);
				found_q   <= 1'b0;
				ok_q      <= 1'b0;
				changed_q <= 1'b0;
				if (mode == MODE_TICK) begin
					cursor_q <= '0;
				end
			end

			// Search for the lowest free slot.
			if (cmd.set_step) begin
				if (set_free) begin
					live_q[cnt_ix] <= 1'b1;
					ok_q           <= 1'b1;
					if (dur_q < DUR_W'(next_q)) begin
						next_q    <= dur_q[PER_W-1:0];
						elapsed_q <= dur_q[PER_W-1:0];
						changed_q <= 1'b1;
					end
				end else if (issue_ok) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end

			// Tick countdown and fetch scan over the RAM.
			if (cmd.ram_step) begin
				if (issue_ok) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (tick_hit) begin
					if (tick_r == '0) begin
						if (tally_q != TALLY_MAX) begin
							tally_q <= tally_q + 1'b1;
						end
					end else if (tick_r < DUR_W'(nxt_q)) begin
						nxt_q <= tick_r[PER_W-1:0];
					end
				end
				if (fetch_hit) begin
					live_q[idx_s1] <= 1'b0;
					found_q        <= 1'b1;
					cursor_q       <= CW'(idx_s1);
					if (tally_q != '0) begin
						tally_q <= tally_q - 1'b1;
					end
				end
			end

			// End of the item.
			if (cmd.finish) begin
				tally_q <= tally_fin;
				next_q  <= period_fin;
				if (mode_q == MODE_TICK) begin
					elapsed_q <= nxt_q;
				end
				if (mode_q == MODE_FETCH && !found_q) begin
					cursor_q <= CW'(SLOTS);
				end
				if (mode_q == MODE_REMOVE && remove_ok) begin
					live_q[IW'(sidx_q)] <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire
